// ===== rtl/core/slr_pkg.sv =====
// Shared constants for the stereo linear resampler: register widths, register
// indexes, default parameter values and sequencer state codes.
// No dependencies.
package slr_pkg;

  // Default parameter values
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_RUN_DEF     = 32;

  // Rate registers and phase accumulator
  localparam int REG_W      = 17;
  localparam int PHASE_W    = 18;
  localparam int CFG_ADDR_W = 1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_PERIOD = 1'b1;

  // Sequencer states
  localparam int SEQ_W = 2;
  localparam logic [SEQ_W-1:0] S_IDLE  = 2'd0;
  localparam logic [SEQ_W-1:0] S_CHECK = 2'd1;
  localparam logic [SEQ_W-1:0] S_CALC  = 2'd2;
  localparam logic [SEQ_W-1:0] S_PUSH  = 2'd3;

endpackage

// ===== rtl/core/slr_lane.sv =====
// One channel lane: weighted sum of two samples and a bit-serial divide by the
// period, truncated toward zero. Depends on slr_pkg.
module slr_lane import slr_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] smp_a,
  input  logic signed [SAMPLE_BITS-1:0] smp_b,
  input  logic        [REG_W-1:0]       wt_a,
  input  logic        [REG_W-1:0]       wt_b,
  input  logic        [REG_W-1:0]       per,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_W = SAMPLE_BITS + REG_W + 1;
  localparam int NUM_W  = PROD_W + 1;
  localparam int CNT_W  = $clog2(SAMPLE_BITS + 1);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_ADD  = 2'd1;
  localparam logic [1:0] L_DIV  = 2'd2;
  localparam logic [1:0] L_FIN  = 2'd3;

  logic [1:0]               lst_r, lst_nxt;
  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic                     neg_r;
  logic [REG_W-1:0]         rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0]   shr_r, shr_nxt;
  logic [SAMPLE_BITS-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         mag;
  logic [REG_W:0]           trial;
  logic                     ge;
  logic [REG_W:0]           diff;

  // Sum of products and its magnitude
  assign num = NUM_W'(pa_r) + NUM_W'(pb_r);
  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // One restoring divide step
  assign trial = {rem_r, shr_r[SAMPLE_BITS-1]};
  assign ge    = trial >= {1'b0, per};
  assign diff  = trial - {1'b0, per};

  always_comb begin
    lst_nxt = lst_r;
    rem_nxt = rem_r;
    shr_nxt = shr_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    case (lst_r)
      L_IDLE: begin
        if (start) begin
          lst_nxt = L_ADD;
        end
      end
      L_ADD: begin
        // upper part is below the period since the quotient fits the sample width
        rem_nxt = mag[SAMPLE_BITS+REG_W-1:SAMPLE_BITS];
        shr_nxt = mag[SAMPLE_BITS-1:0];
        quo_nxt = '0;
        cnt_nxt = CNT_W'(SAMPLE_BITS);
        lst_nxt = L_DIV;
      end
      L_DIV: begin
        rem_nxt = ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
        shr_nxt = {shr_r[SAMPLE_BITS-2:0], 1'b0};
        quo_nxt = {quo_r[SAMPLE_BITS-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          lst_nxt = L_FIN;
        end
      end
      L_FIN: begin
        lst_nxt = L_IDLE;
      end
      default: begin
        lst_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lst_r <= L_IDLE;
    end else begin
      lst_r <= lst_nxt;
    end
  end

  // Payload registers: products, sign, divider
  always_ff @(posedge clk) begin
    if (start && lst_r == L_IDLE) begin
      pa_r <= PROD_W'(smp_a) * PROD_W'($signed({1'b0, wt_a}));
      pb_r <= PROD_W'(smp_b) * PROD_W'($signed({1'b0, wt_b}));
    end
    if (lst_r == L_ADD) begin
      neg_r <= num[NUM_W-1];
    end
    rem_r <= rem_nxt;
    shr_r <= shr_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  // Restore the sign; holds until the next start
  assign result = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign done   = (lst_r == L_FIN);

endmodule

// ===== rtl/core/stereo_linear_resampler.sv =====
// Stereo linear-interpolation resampler with a phase accumulator.
// Each input sample (after the first) is paired with the previous one and
// yields zero or more interpolated outputs, at most MAX_RUN per pair plus at
// most MAX_RUN for the flush that a sample marked tlast triggers. Every output
// is worked out by the bit-serial divider in each channel lane, and a stalled
// result side holds it back. Each item also goes through bookkeeping (accept,
// end of the pair run, end of the flush) besides the outputs that it causes.
// A new input is taken only when the previous one has been fully worked off;
// the output register lets the next input in while the last result still
// waits. phase_period of 0 acts as 1.
// Depends on slr_pkg and slr_lane.
module stereo_linear_resampler import slr_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,  // left_in, right_in
  input  logic                                    in_tlast,  // final_sample
  // result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      out_tdata, // left_out, right_out
  output logic                                    out_tlast, // run_end
  output logic                                    out_tuser, // stream_done
  // configuration
  input  logic                                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]                   cfg_addr,
  input  logic [REG_W-1:0]                        cfg_wdata
);

  localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int KW     = $clog2(MAX_RUN + 1);
  localparam logic [KW:0] MAX_RUN_K = (KW+1)'(MAX_RUN);

  logic [SEQ_W-1:0]              state_r, state_nxt;
  logic [REG_W-1:0]              step_r, period_r;
  logic [REG_W-1:0]              per_r, per_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic                          flush_r, flush_nxt;
  logic                          last_r, last_nxt;
  logic [PHASE_W-1:0]            phase_r, phase_nxt;
  logic [KW-1:0]                 k_r, k_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_l_r, prev_l_nxt, prev_rt_r, prev_rt_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_l_r, cur_l_nxt, cur_rt_r, cur_rt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_l_r, out_rt_r;
  logic                          out_end_r, out_done_r;
  logic                          out_load;

  logic signed [SAMPLE_BITS-1:0] in_l, in_rt;
  logic                          in_acc;
  logic                          emit_ok;
  logic                          lane_start;
  logic signed [SAMPLE_BITS-1:0] a_l, a_rt, b_l, b_rt;
  logic [REG_W-1:0]              wt_a, wt_b;
  logic                          done_l, done_rt;
  logic signed [SAMPLE_BITS-1:0] res_l, res_rt;

  logic [PHASE_W-1:0]            sum;
  logic [PHASE_W-1:0]            wrap;
  logic [PHASE_W-1:0]            p2;
  logic                          ends_next, flush_emit, run_end;

  assign in_l  = in_tdata[SAMPLE_BITS-1:0];
  assign in_rt = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Output register doubles as the merge of both lanes
  assign out_load = (state_r == S_PUSH) && (!out_valid_r || out_tready);

  // Emission test and lane operands
  assign emit_ok    = ({1'b0, k_r} < MAX_RUN_K) && (phase_r < {1'b0, per_r});
  assign lane_start = (state_r == S_CHECK) && emit_ok;
  assign a_l  = flush_r ? cur_l_r  : prev_l_r;
  assign a_rt = flush_r ? cur_rt_r : prev_rt_r;
  assign b_l  = flush_r ? '0 : cur_l_r;
  assign b_rt = flush_r ? '0 : cur_rt_r;
  assign wt_b = phase_r[REG_W-1:0];
  assign wt_a = per_r - phase_r[REG_W-1:0];

  // End-of-run prediction for the result being pushed
  assign sum        = phase_r + PHASE_W'(step_r);
  assign wrap       = (phase_r >= {1'b0, per_r}) ? phase_r - {1'b0, per_r} : '0;
  assign ends_next  = (({1'b0, k_r} + 1'b1) >= MAX_RUN_K) || (sum >= {1'b0, per_r});
  assign p2         = (sum >= {1'b0, per_r}) ? sum - {1'b0, per_r} : '0;
  assign flush_emit = last_r && (p2 < {1'b0, per_r});
  assign run_end    = flush_r ? (ends_next || (phase_r == '0))
                              : (ends_next && !flush_emit);

  slr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .smp_a  (a_l),
    .smp_b  (b_l),
    .wt_a   (wt_a),
    .wt_b   (wt_b),
    .per    (per_r),
    .done   (done_l),
    .result (res_l)
  );

  slr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .smp_a  (a_rt),
    .smp_b  (b_rt),
    .wt_a   (wt_a),
    .wt_b   (wt_b),
    .per    (per_r),
    .done   (done_rt),
    .result (res_rt)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    per_nxt       = per_r;
    have_prev_nxt = have_prev_r;
    flush_nxt     = flush_r;
    last_nxt      = last_r;
    phase_nxt     = phase_r;
    k_nxt         = k_r;
    prev_l_nxt    = prev_l_r;
    prev_rt_nxt   = prev_rt_r;
    cur_l_nxt     = cur_l_r;
    cur_rt_nxt    = cur_rt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cur_l_nxt  = in_l;
          cur_rt_nxt = in_rt;
          last_nxt   = in_tlast;
          per_nxt    = (period_r == '0) ? REG_W'(1) : period_r;
          k_nxt      = '0;
          if (have_prev_r) begin
            flush_nxt = 1'b0;
            state_nxt = S_CHECK;
          end else begin
            // first sample: store only, flush at once if marked last
            have_prev_nxt = 1'b1;
            phase_nxt     = '0;
            prev_l_nxt    = in_l;
            prev_rt_nxt   = in_rt;
            flush_nxt     = 1'b1;
            state_nxt     = in_tlast ? S_CHECK : S_IDLE;
          end
        end
      end
      S_CHECK: begin
        if (emit_ok) begin
          state_nxt = S_CALC;
        end else if (!flush_r) begin
          // pair run over: wrap phase, advance the pair
          phase_nxt   = wrap;
          prev_l_nxt  = cur_l_r;
          prev_rt_nxt = cur_rt_r;
          if (last_r) begin
            flush_nxt = 1'b1;
            k_nxt     = '0;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          have_prev_nxt = 1'b0;
          phase_nxt     = '0;
          prev_l_nxt    = '0;
          prev_rt_nxt   = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_CALC: begin
        if (done_l && done_rt) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_load) begin
          if (flush_r && phase_r == '0) begin
            have_prev_nxt = 1'b0;
            phase_nxt     = '0;
            prev_l_nxt    = '0;
            prev_rt_nxt   = '0;
            state_nxt     = S_IDLE;
          end else begin
            phase_nxt = sum;
            k_nxt     = k_r + 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      flush_r     <= 1'b0;
      last_r      <= 1'b0;
      phase_r     <= '0;
      k_r         <= '0;
      prev_l_r    <= '0;
      prev_rt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      flush_r     <= flush_nxt;
      last_r      <= last_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      prev_l_r    <= prev_l_nxt;
      prev_rt_r   <= prev_rt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    per_r    <= per_nxt;
    cur_l_r  <= cur_l_nxt;
    cur_rt_r <= cur_rt_nxt;
  end

  // Rate registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= REG_W'(1);
      period_r <= REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PHASE_STEP:   step_r   <= cfg_wdata;
        REG_PHASE_PERIOD: period_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Output register: hold until the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r    <= res_l;
      out_rt_r   <= res_rt;
      out_end_r  <= run_end;
      out_done_r <= run_end && last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({out_rt_r, out_l_r});
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_done_r;

endmodule
